### src/latching_relay_blink_driver_core_defines.svh
// ----------------------------------------------------------------------------
// latching relay blink driver assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef LATCHING_RELAY_BLINK_DRIVER_CORE_DEFINES_SVH
`define LATCHING_RELAY_BLINK_DRIVER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LRBD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LRBD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/lrbd_pkg.sv
// ----------------------------------------------------------------------------
// lrbd_pkg
// types and constants shared by the relay blink driver modules
// ----------------------------------------------------------------------------
package lrbd_pkg;

   // field widths
   localparam int unsigned FUNC_W  = 2;
   localparam int unsigned MS_W    = 16;
   localparam int unsigned TICKS_W = 16;
   localparam int unsigned CYCLE_W = 10;

   // command codes
   localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET_ON  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SET_OFF = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_BLINK   = 2'd3;

   // shortest blink phase in ms and reset tick period
   localparam logic [MS_W-1:0]    MIN_BLINK_MS     = 16'd50;
   localparam logic [CYCLE_W-1:0] CYCLE_TIME_RESET = 10'd10;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [MS_W-1:0]   on_time_ms;
      logic [MS_W-1:0]   off_time_ms;
      logic [TICKS_W-1:0] repeat_total;
   } req_data_type;

   typedef struct packed {
      logic on_coil_drive;
      logic off_coil_drive;
      logic relay_closed;
      logic relay_commanded;
      logic blink_active;
   } rsp_data_type;

   // controller to datapath
   typedef struct packed {
      logic accept_simple;
      logic accept_blink;
      logic commit_blink;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic rsp_free;
   } dp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_COMMIT = 3'b100
   } ctrl_state_type;

endpackage

### src/lrbd_divider.sv
// ----------------------------------------------------------------------------
// lrbd_divider
// restoring divider, one quotient bit per cycle, quotient held until restart
// ----------------------------------------------------------------------------
module lrbd_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lrbd_pkg::MS_W-1:0]         dividend,
   input  logic [lrbd_pkg::CYCLE_W-1:0]      divisor,
   output logic [lrbd_pkg::TICKS_W-1:0]      quotient,
   output logic                              done
);

   localparam int unsigned STEPS   = lrbd_pkg::MS_W;
   localparam int unsigned CNT_W   = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [lrbd_pkg::CYCLE_W-1:0]  rem_ff, rem_in;
   logic [lrbd_pkg::CYCLE_W-1:0]  div_ff, div_in;
   logic [lrbd_pkg::MS_W-1:0]     quo_ff, quo_in;
   logic [lrbd_pkg::CYCLE_W:0]    trial;
   logic                          fits;

   // trial subtract of the shifted remainder
   assign trial = {rem_ff, quo_ff[lrbd_pkg::MS_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         div_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? lrbd_pkg::CYCLE_W'(trial - {1'b0, div_ff})
                         : trial[lrbd_pkg::CYCLE_W-1:0];
         quo_in   = {quo_ff[lrbd_pkg::MS_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

### src/lrbd_datapath.sv
// ----------------------------------------------------------------------------
// lrbd_datapath
// relay and blink state, tick update, blink time conversion, result register
// ----------------------------------------------------------------------------
module lrbd_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  lrbd_pkg::ctrl_cmd_type        cmd,
   output lrbd_pkg::dp_status_type       status,
   input  lrbd_pkg::req_data_type        req_data,
   input  logic                          csr_write_enable,
   input  logic [lrbd_pkg::CYCLE_W-1:0]  csr_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lrbd_pkg::rsp_data_type        rsp_data
);

   logic [lrbd_pkg::CYCLE_W-1:0] cycle_time_ff, cycle_time_in;
   logic cmd_ff, cmd_in;
   logic act_ff, act_in;
   logic pulse_ff, pulse_in;
   logic set_ff, set_in;
   logic rst_coil_ff, rst_coil_in;
   logic blink_ff, blink_in;
   logic [lrbd_pkg::TICKS_W-1:0] phase_ff, phase_in;
   logic [lrbd_pkg::TICKS_W-1:0] rep_ff, rep_in;
   logic [lrbd_pkg::TICKS_W-1:0] on_ticks_ff, on_ticks_in;
   logic [lrbd_pkg::TICKS_W-1:0] off_ticks_ff, off_ticks_in;
   logic [lrbd_pkg::TICKS_W-1:0] rep_cap_ff, rep_cap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   lrbd_pkg::rsp_data_type       rsp_data_ff, rsp_data_in;

   logic [lrbd_pkg::MS_W-1:0]    on_ms_clamped, off_ms_clamped;
   logic [lrbd_pkg::CYCLE_W-1:0] divisor;
   logic [lrbd_pkg::TICKS_W-1:0] on_quo, off_quo;
   logic                         on_done, off_done;
   logic                         load_rsp;

   // blink times raised to the minimum, zero period taken as one
   assign on_ms_clamped  = (req_data.on_time_ms < lrbd_pkg::MIN_BLINK_MS)
                           ? lrbd_pkg::MIN_BLINK_MS : req_data.on_time_ms;
   assign off_ms_clamped = (req_data.off_time_ms < lrbd_pkg::MIN_BLINK_MS)
                           ? lrbd_pkg::MIN_BLINK_MS : req_data.off_time_ms;
   assign divisor = (cycle_time_ff == '0) ? lrbd_pkg::CYCLE_W'(1) : cycle_time_ff;

   // on and off times divided side by side
   lrbd_divider u_div_on (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.accept_blink),
      .dividend (on_ms_clamped),
      .divisor  (divisor),
      .quotient (on_quo),
      .done     (on_done)
   );

   lrbd_divider u_div_off (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.accept_blink),
      .dividend (off_ms_clamped),
      .divisor  (divisor),
      .quotient (off_quo),
      .done     (off_done)
   );

   assign cycle_time_in = csr_write_enable ? csr_write_data : cycle_time_ff;
   assign rep_cap_in    = cmd.accept_blink ? req_data.repeat_total : rep_cap_ff;
   assign load_rsp      = cmd.accept_simple | cmd.commit_blink;

   // next relay and blink state
   always_comb begin
      cmd_in       = cmd_ff;
      act_in       = act_ff;
      pulse_in     = pulse_ff;
      set_in       = set_ff;
      rst_coil_in  = rst_coil_ff;
      blink_in     = blink_ff;
      phase_in     = phase_ff;
      rep_in       = rep_ff;
      on_ticks_in  = on_ticks_ff;
      off_ticks_in = off_ticks_ff;
      if (cmd.accept_simple) begin
         case (req_data.func)
            lrbd_pkg::FUNC_TICK: begin
               // set coil side: energise, then release and latch closed
               if (cmd_ff && !act_ff) begin
                  if (!pulse_ff) begin
                     set_in   = 1'b1;
                     pulse_in = 1'b1;
                  end else begin
                     set_in   = 1'b0;
                     pulse_in = 1'b0;
                     act_in   = 1'b1;
                  end
               end
               // reset coil side: energise, then release and latch open
               if (!cmd_ff && act_ff) begin
                  if (!pulse_ff) begin
                     rst_coil_in = 1'b1;
                     pulse_in    = 1'b1;
                  end else begin
                     rst_coil_in = 1'b0;
                     pulse_in    = 1'b0;
                     act_in      = 1'b0;
                  end
               end
               // blink phase sequencing
               if (blink_ff) begin
                  if (phase_ff != '0) begin
                     phase_in = phase_ff - 1'b1;
                  end else if (cmd_ff) begin
                     cmd_in   = 1'b0;
                     phase_in = off_ticks_ff;
                  end else if (rep_ff != lrbd_pkg::TICKS_W'(1)) begin
                     cmd_in   = 1'b1;
                     phase_in = on_ticks_ff;
                     if (rep_ff > lrbd_pkg::TICKS_W'(1)) begin
                        rep_in = rep_ff - 1'b1;
                     end
                  end else begin
                     blink_in = 1'b0;
                  end
               end
            end
            lrbd_pkg::FUNC_SET_ON: begin
               cmd_in = 1'b1;
            end
            lrbd_pkg::FUNC_SET_OFF: begin
               cmd_in = 1'b0;
            end
            default: begin
               cmd_in = cmd_ff;
            end
         endcase
      end
      if (cmd.commit_blink) begin
         on_ticks_in  = on_quo;
         off_ticks_in = off_quo;
         phase_in     = on_quo;
         rep_in       = rep_cap_ff;
         cmd_in       = 1'b1;
         blink_in     = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_data_in.on_coil_drive   = set_in;
      rsp_data_in.off_coil_drive  = rst_coil_in;
      rsp_data_in.relay_closed    = act_in;
      rsp_data_in.relay_commanded = cmd_in;
      rsp_data_in.blink_active    = blink_in;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_time_ff <= lrbd_pkg::CYCLE_TIME_RESET;
         cmd_ff        <= 1'b0;
         act_ff        <= 1'b0;
         pulse_ff      <= 1'b0;
         set_ff        <= 1'b0;
         rst_coil_ff   <= 1'b0;
         blink_ff      <= 1'b0;
         phase_ff      <= '0;
         rep_ff        <= '0;
         on_ticks_ff   <= '0;
         off_ticks_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cycle_time_ff <= cycle_time_in;
         cmd_ff        <= cmd_in;
         act_ff        <= act_in;
         pulse_ff      <= pulse_in;
         set_ff        <= set_in;
         rst_coil_ff   <= rst_coil_in;
         blink_ff      <= blink_in;
         phase_ff      <= phase_in;
         rep_ff        <= rep_in;
         on_ticks_ff   <= on_ticks_in;
         off_ticks_ff  <= off_ticks_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rep_cap_ff <= rep_cap_in;
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.div_done = on_done & off_done;
   assign status.rsp_free = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

endmodule

### src/lrbd_controller.sv
// ----------------------------------------------------------------------------
// lrbd_controller
// sequences acceptance, blink time conversion and result commit
// ----------------------------------------------------------------------------
module lrbd_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lrbd_pkg::FUNC_W-1:0]   req_func,
   input  lrbd_pkg::dp_status_type       status,
   output lrbd_pkg::ctrl_cmd_type        cmd
);

   lrbd_pkg::ctrl_state_type state_ff, state_in;
   logic accept;

   // take a command only when idle and the result register frees up
   assign req_stall = ~((state_ff == lrbd_pkg::ST_IDLE) & status.rsp_free);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in          = state_ff;
      cmd.accept_simple = 1'b0;
      cmd.accept_blink  = 1'b0;
      cmd.commit_blink  = 1'b0;
      case (state_ff)
         lrbd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_func == lrbd_pkg::FUNC_BLINK) begin
                  cmd.accept_blink = 1'b1;
                  state_in         = lrbd_pkg::ST_DIVIDE;
               end else begin
                  cmd.accept_simple = 1'b1;
               end
            end
         end
         lrbd_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = lrbd_pkg::ST_COMMIT;
            end
         end
         lrbd_pkg::ST_COMMIT: begin
            if (status.rsp_free) begin
               cmd.commit_blink = 1'b1;
               state_in         = lrbd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lrbd_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrbd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/latching_relay_blink_driver_core.sv
// ----------------------------------------------------------------------------
// latching_relay_blink_driver_core
// bistable relay coil driver with tick-timed pulses and blink sequencing
// ----------------------------------------------------------------------------
// Each command gives one result. Tick, set-on and set-off are handled in the
// cycle they are taken, and a new command can follow every cycle as long as
// the result side keeps up. Start-blink converts both blink times from ms to
// ticks with two 16-step restoring dividers running side by side, and the next
// command is taken only after it has passed the divide and commit states. The
// tick period register may only be written while no command is in flight.
module latching_relay_blink_driver_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lrbd_pkg::req_data_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lrbd_pkg::rsp_data_type        rsp_data,
   input  logic                          csr_write_enable,
   input  logic [lrbd_pkg::CYCLE_W-1:0]  csr_write_data
);

   lrbd_pkg::ctrl_cmd_type  cmd;
   lrbd_pkg::dp_status_type status;

   // sequencing
   lrbd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_data.func),
      .status    (status),
      .cmd       (cmd)
   );

   // state and arithmetic
   lrbd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

### src/lrbd_checker.sv
// ----------------------------------------------------------------------------
// lrbd_checker
// port-level checks on the relay blink driver results
// ----------------------------------------------------------------------------
`include "latching_relay_blink_driver_core_defines.svh"

module lrbd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input lrbd_pkg::rsp_data_type rsp_data
);

   // never both coils at once
   `LRBD_ASSERT_IMPLY(a_coils_exclusive, clock, reset, rsp_valid, !(rsp_data.on_coil_drive && rsp_data.off_coil_drive), "both coils energised")

   // set coil only drives an open relay
   `LRBD_ASSERT_IMPLY(a_set_coil_open, clock, reset, rsp_valid && rsp_data.on_coil_drive, !rsp_data.relay_closed, "set coil on closed relay")

   // reset coil only drives a closed relay
   `LRBD_ASSERT_IMPLY(a_reset_coil_closed, clock, reset, rsp_valid && rsp_data.off_coil_drive, rsp_data.relay_closed, "reset coil on open relay")

   // stalled result holds
   `LRBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind latching_relay_blink_driver_core lrbd_checker u_lrbd_checker (.*);
